// ===== hw/rtl/jbt_pkg.sv =====
// Shared types and codes for the JSON byte tokenizer.
// No dependencies; used by jbt_front, jbt_fifo, jbt_back and the top level.
package jbt_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int MAX_TOKENS      = 3;

    // token types
    localparam logic [3:0] TT_START   = 4'd0;
    localparam logic [3:0] TT_LBRACE  = 4'd1;
    localparam logic [3:0] TT_RBRACE  = 4'd2;
    localparam logic [3:0] TT_LBRACK  = 4'd3;
    localparam logic [3:0] TT_RBRACK  = 4'd4;
    localparam logic [3:0] TT_COLON   = 4'd5;
    localparam logic [3:0] TT_COMMA   = 4'd6;
    localparam logic [3:0] TT_STRING  = 4'd7;
    localparam logic [3:0] TT_NUMBER  = 4'd8;
    localparam logic [3:0] TT_BOOLEAN = 4'd9;
    localparam logic [3:0] TT_NULL    = 4'd10;
    localparam logic [3:0] TT_END     = 4'd11;
    localparam logic [3:0] TT_ERROR   = 4'd12;

    // error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_UNTERM = 2'd1;
    localparam logic [1:0] ERR_UNEXP  = 2'd2;

    typedef struct packed {
        logic [3:0]  ttype;
        logic [31:0] offset;
        logic [31:0] length;
        logic [1:0]  err;
    } t_tok;

    // all tokens caused by one byte; cnt is 1..3 when queued
    typedef struct packed {
        logic [1:0]           cnt;
        t_tok [MAX_TOKENS-1:0] tok;
    } t_bundle;

endpackage

// ===== hw/rtl/jbt_front.sv =====
// Front end: accepts text bytes, classifies them and updates the scan state.
// Emits one bundle of up to three tokens for each byte that yields any. Depends on jbt_pkg.
module jbt_front #(
    parameter int OFFSET_BITS = jbt_pkg::OFFSET_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_text_byte,
    input  logic             i_final_byte,
    input  logic             i_full,
    output logic             o_push,
    output jbt_pkg::t_bundle o_bundle
);

    localparam logic [OFFSET_BITS-1:0] PosMax = '1;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LC_E   = 8'h65;
    localparam logic [7:0] CH_UC_E   = 8'h45;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [1:0] W_NULL  = 2'd0;
    localparam logic [1:0] W_TRUE  = 2'd1;
    localparam logic [1:0] W_FALSE = 2'd2;

    localparam int NCAND = 5;

    typedef enum logic [5:0] {
        M_IDLE    = 6'b000001,
        M_NORMAL  = 6'b000010,
        M_STRING  = 6'b000100,
        M_NUMBER  = 6'b001000,
        M_LITERAL = 6'b010000,
        M_DROP    = 6'b100000
    } t_mode;

    typedef enum logic [2:0] {
        CK_SPACE,
        CK_PUNCT,
        CK_QUOTE,
        CK_WORD,
        CK_NUM,
        CK_BAD
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] ttype;
        logic [1:0] word;
    } t_cls;

    function automatic t_cls classify(input logic [7:0] b);
        t_cls c;
        c.kind  = CK_BAD;
        c.ttype = jbt_pkg::TT_ERROR;
        c.word  = W_NULL;
        priority if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) begin
            c.kind = CK_SPACE;
        end else if (b == CH_LBRACE) begin
            c.kind  = CK_PUNCT;
            c.ttype = jbt_pkg::TT_LBRACE;
        end else if (b == CH_RBRACE) begin
            c.kind  = CK_PUNCT;
            c.ttype = jbt_pkg::TT_RBRACE;
        end else if (b == CH_LBRACK) begin
            c.kind  = CK_PUNCT;
            c.ttype = jbt_pkg::TT_LBRACK;
        end else if (b == CH_RBRACK) begin
            c.kind  = CK_PUNCT;
            c.ttype = jbt_pkg::TT_RBRACK;
        end else if (b == CH_COLON) begin
            c.kind  = CK_PUNCT;
            c.ttype = jbt_pkg::TT_COLON;
        end else if (b == CH_COMMA) begin
            c.kind  = CK_PUNCT;
            c.ttype = jbt_pkg::TT_COMMA;
        end else if (b == CH_QUOTE) begin
            c.kind = CK_QUOTE;
        end else if (b == "n") begin
            c.kind = CK_WORD;
            c.word = W_NULL;
        end else if (b == "t") begin
            c.kind = CK_WORD;
            c.word = W_TRUE;
        end else if (b == "f") begin
            c.kind = CK_WORD;
            c.word = W_FALSE;
        end else if ((b >= CH_ZERO && b <= CH_NINE) || b == CH_MINUS) begin
            c.kind = CK_NUM;
        end else begin
            c.kind = CK_BAD;
        end
        return c;
    endfunction

    function automatic logic is_num_char(input logic [7:0] b);
        return (b >= CH_ZERO && b <= CH_NINE) || b == CH_DOT || b == CH_LC_E ||
               b == CH_UC_E || b == CH_PLUS || b == CH_MINUS;
    endfunction

    function automatic logic [2:0] word_len(input logic [1:0] w);
        return (w == W_FALSE) ? 3'd5 : 3'd4;
    endfunction

    function automatic logic [7:0] word_char(input logic [1:0] w, input logic [2:0] m);
        logic [7:0] c;
        c = 8'h00;
        unique case (w)
            W_TRUE: begin
                unique case (m)
                    3'd0: c = "t";
                    3'd1: c = "r";
                    3'd2: c = "u";
                    3'd3: c = "e";
                    default: c = 8'h00;
                endcase
            end
            W_FALSE: begin
                unique case (m)
                    3'd0: c = "f";
                    3'd1: c = "a";
                    3'd2: c = "l";
                    3'd3: c = "s";
                    3'd4: c = "e";
                    default: c = 8'h00;
                endcase
            end
            default: begin
                unique case (m)
                    3'd0: c = "n";
                    3'd1: c = "u";
                    3'd2: c = "l";
                    3'd3: c = "l";
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic jbt_pkg::t_tok mk_tok(input logic [3:0] t, input logic [31:0] off,
                                             input logic [31:0] len, input logic [1:0] e);
        jbt_pkg::t_tok k;
        k.ttype  = t;
        k.offset = off;
        k.length = len;
        k.err    = e;
        return k;
    endfunction

    t_mode                  r_mode, n_mode;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_begin, n_begin;
    logic                   r_bslash, n_bslash;
    logic [1:0]             r_word, n_word;
    logic [2:0]             r_matched, n_matched;

    logic                   fire;
    t_mode                  mode_eff;
    t_cls                   cls;
    logic                   disp;
    logic [OFFSET_BITS-1:0] pos_nx;
    logic [OFFSET_BITS-1:0] len_cur;
    logic [OFFSET_BITS-1:0] len_fin;
    logic [1:0]             w_sel;
    logic [2:0]             w_len;
    logic                   w_hit;
    logic [NCAND-1:0]       cand_v;
    jbt_pkg::t_tok          cand_tok [NCAND];
    logic [2:0]             cnt;
    jbt_pkg::t_bundle       bundle;

    assign o_ready = !i_full;
    assign fire    = i_valid && !i_full;

    assign pos_nx  = (r_pos == PosMax) ? r_pos : r_pos + OFFSET_BITS'(1);
    assign len_cur = r_pos - r_begin;
    assign cls     = classify(i_text_byte);
    assign w_sel   = (r_word == 2'd3) ? W_NULL : r_word;
    assign w_len   = word_len(w_sel);
    assign w_hit   = (r_matched < w_len) && (i_text_byte == word_char(w_sel, r_matched));

    always_comb begin
        n_mode    = r_mode;
        n_pos     = r_pos;
        n_begin   = r_begin;
        n_bslash  = r_bslash;
        n_word    = r_word;
        n_matched = r_matched;
        disp      = 1'b0;
        cand_v    = '0;
        for (int k = 0; k < NCAND; k++) begin
            cand_tok[k] = '0;
        end

        mode_eff = (r_mode == M_IDLE) ? M_NORMAL : r_mode;
        if (r_mode == M_IDLE) begin
            n_mode      = M_NORMAL;
            cand_v[0]   = 1'b1;
            cand_tok[0] = mk_tok(jbt_pkg::TT_START, 32'd0, 32'd0, jbt_pkg::ERR_NONE);
        end

        unique case (mode_eff)
            M_STRING: begin
                if (i_text_byte == CH_QUOTE && !r_bslash) begin
                    cand_v[1]   = 1'b1;
                    cand_tok[1] = mk_tok(jbt_pkg::TT_STRING, 32'(r_begin), 32'(len_cur),
                                         jbt_pkg::ERR_NONE);
                    n_mode      = M_NORMAL;
                end else begin
                    n_bslash = (i_text_byte == CH_BSLASH);
                end
            end
            M_LITERAL: begin
                if (w_hit) begin
                    n_matched = r_matched + 3'd1;
                    if (r_matched + 3'd1 == w_len) begin
                        cand_v[1]   = 1'b1;
                        cand_tok[1] = mk_tok((w_sel == W_NULL) ? jbt_pkg::TT_NULL
                                                               : jbt_pkg::TT_BOOLEAN,
                                             32'(r_begin), 32'(w_len), jbt_pkg::ERR_NONE);
                        n_mode      = M_NORMAL;
                    end
                end else begin
                    cand_v[1]   = 1'b1;
                    cand_tok[1] = mk_tok(jbt_pkg::TT_ERROR, 32'(r_begin), 32'd0,
                                         jbt_pkg::ERR_UNEXP);
                    n_mode      = M_DROP;
                end
            end
            M_NUMBER: begin
                if (!is_num_char(i_text_byte)) begin
                    cand_v[1]   = 1'b1;
                    cand_tok[1] = mk_tok(jbt_pkg::TT_NUMBER, 32'(r_begin), 32'(len_cur),
                                         jbt_pkg::ERR_NONE);
                    n_mode      = M_NORMAL;
                    disp        = 1'b1;
                end
            end
            M_NORMAL: begin
                disp = 1'b1;
            end
            default: begin
            end
        endcase

        if (disp) begin
            unique case (cls.kind)
                CK_PUNCT: begin
                    cand_v[2]   = 1'b1;
                    cand_tok[2] = mk_tok(cls.ttype, 32'(r_pos), 32'd1, jbt_pkg::ERR_NONE);
                end
                CK_QUOTE: begin
                    n_begin  = pos_nx;
                    n_bslash = 1'b0;
                    n_mode   = M_STRING;
                end
                CK_WORD: begin
                    n_begin   = r_pos;
                    n_word    = cls.word;
                    n_matched = 3'd1;
                    n_mode    = M_LITERAL;
                end
                CK_NUM: begin
                    n_begin = r_pos;
                    n_mode  = M_NUMBER;
                end
                CK_BAD: begin
                    cand_v[2]   = 1'b1;
                    cand_tok[2] = mk_tok(jbt_pkg::TT_ERROR, 32'(r_pos), 32'd0,
                                         jbt_pkg::ERR_UNEXP);
                    n_mode      = M_DROP;
                end
                default: begin
                    // whitespace: skip
                end
            endcase
        end

        len_fin = pos_nx - n_begin;

        if (i_final_byte) begin
            unique case (n_mode)
                M_STRING: begin
                    cand_v[3]   = 1'b1;
                    cand_tok[3] = mk_tok(jbt_pkg::TT_ERROR, 32'(n_begin), 32'd0,
                                         jbt_pkg::ERR_UNTERM);
                end
                M_LITERAL: begin
                    cand_v[3]   = 1'b1;
                    cand_tok[3] = mk_tok(jbt_pkg::TT_ERROR, 32'(n_begin), 32'd0,
                                         jbt_pkg::ERR_UNEXP);
                end
                M_NUMBER: begin
                    cand_v[3]   = 1'b1;
                    cand_tok[3] = mk_tok(jbt_pkg::TT_NUMBER, 32'(n_begin), 32'(len_fin),
                                         jbt_pkg::ERR_NONE);
                    cand_v[4]   = 1'b1;
                    cand_tok[4] = mk_tok(jbt_pkg::TT_END, 32'(pos_nx), 32'd0,
                                         jbt_pkg::ERR_NONE);
                end
                M_NORMAL: begin
                    cand_v[4]   = 1'b1;
                    cand_tok[4] = mk_tok(jbt_pkg::TT_END, 32'(pos_nx), 32'd0,
                                         jbt_pkg::ERR_NONE);
                end
                default: begin
                end
            endcase
            // text done: back to reset state
            n_mode    = M_IDLE;
            n_pos     = '0;
            n_begin   = '0;
            n_bslash  = 1'b0;
            n_word    = W_NULL;
            n_matched = 3'd0;
        end else begin
            n_pos = pos_nx;
        end

        // pack the candidates in order
        cnt    = 3'd0;
        bundle = '0;
        for (int k = 0; k < NCAND; k++) begin
            if (cand_v[k]) begin
                if (cnt < 3'(jbt_pkg::MAX_TOKENS)) begin
                    bundle.tok[cnt[1:0]] = cand_tok[k];
                end
                cnt = cnt + 3'd1;
            end
        end
        bundle.cnt = cnt[1:0];
    end

    assign o_push   = fire && (cnt != 3'd0);
    assign o_bundle = bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_IDLE;
            r_pos     <= '0;
            r_begin   <= '0;
            r_bslash  <= 1'b0;
            r_word    <= W_NULL;
            r_matched <= 3'd0;
        end else if (fire) begin
            r_mode    <= n_mode;
            r_pos     <= n_pos;
            r_begin   <= n_begin;
            r_bslash  <= n_bslash;
            r_word    <= n_word;
            r_matched <= n_matched;
        end
    end

endmodule

// ===== hw/rtl/jbt_fifo.sv =====
// Short queue of token bundles between the front and back ends.
// Depends on jbt_pkg for the bundle type.
module jbt_fifo #(
    parameter int DEPTH = jbt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  jbt_pkg::t_bundle i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output jbt_pkg::t_bundle o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

    jbt_pkg::t_bundle r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LastIdx) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LastIdx) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/jbt_back.sv =====
// Back end: takes bundles from the queue and hands out their tokens one per transfer.
// Depends on jbt_pkg for the bundle and token types.
module jbt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  jbt_pkg::t_bundle i_data,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [3:0]       o_token_type,
    output logic [31:0]      o_token_offset,
    output logic [31:0]      o_token_length,
    output logic [1:0]       o_error_code,
    output logic             o_last_result
);

    jbt_pkg::t_bundle r_cur;
    logic             r_have;
    logic [1:0]       r_idx;
    logic             last_slot;
    logic             advance;
    jbt_pkg::t_tok    tok;

    assign last_slot = (r_idx == r_cur.cnt - 2'd1);
    assign advance   = !r_have || (i_ready && last_slot);
    assign o_pop     = advance && !i_empty;
    assign o_valid   = r_have;
    assign tok       = r_cur.tok[r_idx];

    assign o_token_type   = tok.ttype;
    assign o_token_offset = tok.offset;
    assign o_token_length = tok.length;
    assign o_error_code   = tok.err;
    assign o_last_result  = last_slot;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_idx  <= 2'd0;
        end else if (advance) begin
            // load the next bundle, or go empty
            r_have <= !i_empty;
            r_idx  <= 2'd0;
        end else if (i_ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

// ===== hw/rtl/json_byte_tokenizer_top.sv =====
// Top level of the JSON byte tokenizer: front end, bundle queue, back end.
// Depends on jbt_pkg, jbt_front, jbt_fifo and jbt_back.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------
//  input   | in        | i_in_valid / o_in_ready   | i_text_byte, i_final_byte
//  output  | out       | o_out_valid / i_out_ready | o_token_type, o_token_offset,
//          |           |                           | o_token_length, o_error_code,
//          |           |                           | o_last_result
//
// One byte is taken per cycle while the queue has room; its tokens (0 to 3) are
// classified in the same cycle and, if there are any, queued as one bundle.
// The back end hands out one token per cycle while the receiver is ready and tokens
// are waiting; the queue absorbs bursts of multi-token bytes.
// The first token of a byte is registered in the queue and then in the back end.
// Reset is synchronous and active low; no clearing pass is needed.
module json_byte_tokenizer_top #(
    parameter int OFFSET_BITS = jbt_pkg::OFFSET_BITS_DEF,
    parameter int QUEUE_DEPTH = jbt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_final_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_token_type,
    output logic [31:0] o_token_offset,
    output logic [31:0] o_token_length,
    output logic [1:0]  o_error_code,
    output logic        o_last_result
);

    logic             q_full, q_empty, q_push, q_pop;
    jbt_pkg::t_bundle q_wdata, q_rdata;

    jbt_front #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_text_byte (i_text_byte),
        .i_final_byte(i_final_byte),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_bundle    (q_wdata)
    );

    jbt_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_wdata),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_empty(q_empty),
        .o_data (q_rdata)
    );

    jbt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (q_empty),
        .i_data        (q_rdata),
        .o_pop         (q_pop),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_token_type  (o_token_type),
        .o_token_offset(o_token_offset),
        .o_token_length(o_token_length),
        .o_error_code  (o_error_code),
        .o_last_result (o_last_result)
    );

    // error tokens carry no text
    a_err_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_type == jbt_pkg::TT_ERROR |-> o_token_length == 32'd0)
        else $error("error token with non-zero length");

    // an error code only ever rides on an error token
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_type != jbt_pkg::TT_ERROR
            |-> o_error_code == jbt_pkg::ERR_NONE)
        else $error("error code on a non-error token");

    // a start marker sits at offset zero and carries no text
    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_type == jbt_pkg::TT_START
            |-> o_token_offset == 32'd0 && o_token_length == 32'd0)
        else $error("start marker with non-zero offset or length");

    // the queue is never pushed while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("bundle queue overflow");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for json_byte_tokenizer_top: directed texts, then random texts.
// Predicts every token in a scanner model of its own; depends on jbt_pkg and the RTL.
module tb_top;

    localparam int CYCLE_LIMIT  = 400000;
    // the directed texts add about 44 bytes on top of these
    localparam int RANDOM_BYTES = 186;

    typedef enum logic [5:0] {
        SCAN_IDLE   = 6'b000001,
        SCAN_NORMAL = 6'b000010,
        SCAN_STRING = 6'b000100,
        SCAN_NUMBER = 6'b001000,
        SCAN_WORD   = 6'b010000,
        SCAN_DROP   = 6'b100000
    } t_scan;

    typedef struct {
        jbt_pkg::t_tok tok;
        logic          last;
    } t_queued_token;

    typedef logic [7:0] t_text [$];

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_text_byte;
    logic        i_final_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [3:0]  o_token_type;
    logic [31:0] o_token_offset;
    logic [31:0] o_token_length;
    logic [1:0]  o_error_code;
    logic        o_last_result;

    // scanner state of the predictor
    t_scan       scan_mode;
    logic [31:0] scan_pos;
    logic [31:0] tok_begin;
    logic        prev_bs;
    logic [1:0]  word_sel;
    logic [2:0]  word_seen;
    string       keyword_spelling [3] = '{"null", "true", "false"};

    jbt_pkg::t_tok step_tokens [$];
    t_queued_token pending_tokens [$];

    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  counted_bytes = 0;
    bit  in_idle_en = 1'b1;
    bit  out_idle_en = 1'b1;

    json_byte_tokenizer_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_text_byte    (i_text_byte),
        .i_final_byte   (i_final_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_token_type   (o_token_type),
        .o_token_offset (o_token_offset),
        .o_token_length (o_token_length),
        .o_error_code   (o_error_code),
        .o_last_result  (o_last_result)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [31:0] pos_inc(input logic [31:0] p);
        return (p == 32'hFFFF_FFFF) ? p : p + 32'd1;
    endfunction

    function automatic void reset_scanner();
        scan_mode = SCAN_IDLE;
        scan_pos  = '0;
        tok_begin = '0;
        prev_bs   = 1'b0;
        word_sel  = '0;
        word_seen = '0;
    endfunction

    function automatic void emit_token(input logic [3:0] tt, input logic [31:0] off,
                                       input logic [31:0] len, input logic [1:0] err);
        jbt_pkg::t_tok t;
        if (step_tokens.size() < jbt_pkg::MAX_TOKENS) begin
            t.ttype  = tt;
            t.offset = off;
            t.length = len;
            t.err    = err;
            step_tokens.insert(step_tokens.size(), t);
        end
    endfunction

    function automatic bit is_number_char(input logic [7:0] b);
        return (b >= "0" && b <= "9") || b == "." || b == "e" || b == "E" ||
               b == "+" || b == "-";
    endfunction

    // Classify a byte seen between tokens: punctuation, token opener, blank or error.
    function automatic void open_token(input logic [7:0] b);
        logic [31:0] p;
        p = scan_pos;
        if (b == 8'd32 || (b >= 8'd9 && b <= 8'd13))
            return;
        case (b)
            "{": emit_token(jbt_pkg::TT_LBRACE, p, 32'd1, jbt_pkg::ERR_NONE);
            "}": emit_token(jbt_pkg::TT_RBRACE, p, 32'd1, jbt_pkg::ERR_NONE);
            "[": emit_token(jbt_pkg::TT_LBRACK, p, 32'd1, jbt_pkg::ERR_NONE);
            "]": emit_token(jbt_pkg::TT_RBRACK, p, 32'd1, jbt_pkg::ERR_NONE);
            ":": emit_token(jbt_pkg::TT_COLON, p, 32'd1, jbt_pkg::ERR_NONE);
            ",": emit_token(jbt_pkg::TT_COMMA, p, 32'd1, jbt_pkg::ERR_NONE);
            "\"": begin
                tok_begin = pos_inc(p);
                prev_bs   = 1'b0;
                scan_mode = SCAN_STRING;
            end
            "n", "t", "f": begin
                tok_begin = p;
                word_sel  = (b == "n") ? 2'd0 : ((b == "t") ? 2'd1 : 2'd2);
                word_seen = 3'd1;
                scan_mode = SCAN_WORD;
            end
            default: begin
                if ((b >= "0" && b <= "9") || b == "-") begin
                    tok_begin = p;
                    scan_mode = SCAN_NUMBER;
                end else begin
                    emit_token(jbt_pkg::TT_ERROR, p, 32'd0, jbt_pkg::ERR_UNEXP);
                    scan_mode = SCAN_DROP;
                end
            end
        endcase
    endfunction

    // Advance the scanner by one accepted byte and queue the tokens it yields.
    function automatic void tokenize_byte(input logic [7:0] b, input logic fin);
        logic [31:0]   p;
        logic [31:0]   end_pos;
        int            w;
        int            m;
        int            wlen;
        t_queued_token q;
        p = scan_pos;
        step_tokens.delete();
        if (scan_mode == SCAN_IDLE) begin
            emit_token(jbt_pkg::TT_START, 32'd0, 32'd0, jbt_pkg::ERR_NONE);
            scan_mode = SCAN_NORMAL;
        end
        case (scan_mode)
            SCAN_STRING: begin
                if (b == "\"" && !prev_bs) begin
                    emit_token(jbt_pkg::TT_STRING, tok_begin, p - tok_begin,
                               jbt_pkg::ERR_NONE);
                    scan_mode = SCAN_NORMAL;
                end else begin
                    prev_bs = (b == "\\");
                end
            end
            SCAN_WORD: begin
                w    = (word_sel < 2'd3) ? int'(word_sel) : 0;
                m    = int'(word_seen);
                wlen = keyword_spelling[w].len();
                if (m < wlen && b == keyword_spelling[w][m]) begin
                    word_seen = 3'(m + 1);
                    if (m + 1 == wlen) begin
                        emit_token((w == 0) ? jbt_pkg::TT_NULL : jbt_pkg::TT_BOOLEAN,
                                   tok_begin, 32'(wlen), jbt_pkg::ERR_NONE);
                        scan_mode = SCAN_NORMAL;
                    end
                end else begin
                    emit_token(jbt_pkg::TT_ERROR, tok_begin, 32'd0, jbt_pkg::ERR_UNEXP);
                    scan_mode = SCAN_DROP;
                end
            end
            SCAN_NUMBER: begin
                if (!is_number_char(b)) begin
                    emit_token(jbt_pkg::TT_NUMBER, tok_begin, p - tok_begin,
                               jbt_pkg::ERR_NONE);
                    scan_mode = SCAN_NORMAL;
                    open_token(b);
                end
            end
            SCAN_NORMAL: open_token(b);
            default: ;
        endcase
        if (fin) begin
            end_pos = pos_inc(p);
            case (scan_mode)
                SCAN_STRING: emit_token(jbt_pkg::TT_ERROR, tok_begin, 32'd0,
                                        jbt_pkg::ERR_UNTERM);
                SCAN_WORD:   emit_token(jbt_pkg::TT_ERROR, tok_begin, 32'd0,
                                        jbt_pkg::ERR_UNEXP);
                SCAN_NUMBER: begin
                    emit_token(jbt_pkg::TT_NUMBER, tok_begin, end_pos - tok_begin,
                               jbt_pkg::ERR_NONE);
                    emit_token(jbt_pkg::TT_END, end_pos, 32'd0, jbt_pkg::ERR_NONE);
                end
                SCAN_NORMAL: emit_token(jbt_pkg::TT_END, end_pos, 32'd0, jbt_pkg::ERR_NONE);
                default: ;
            endcase
            reset_scanner();
        end else begin
            scan_pos = pos_inc(p);
        end
        foreach (step_tokens[i]) begin
            q.tok  = step_tokens[i];
            q.last = (i == step_tokens.size() - 1);
            pending_tokens.insert(pending_tokens.size(), q);
        end
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic note_failure(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", what);
    endtask

    always @(posedge i_clk) begin
        t_queued_token e;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (pending_tokens.size() == 0) begin
                note_failure($sformatf(
                    "unexpected token: type %0d off %0d len %0d err %0d last %0b",
                    o_token_type, o_token_offset, o_token_length, o_error_code,
                    o_last_result));
            end else begin
                e = pending_tokens.pop_front();
                if (o_token_type !== e.tok.ttype || o_token_offset !== e.tok.offset ||
                    o_token_length !== e.tok.length || o_error_code !== e.tok.err ||
                    o_last_result !== e.last) begin
                    note_failure($sformatf({"token mismatch: exp type %0d off %0d len %0d",
                        " err %0d last %0b, got type %0d off %0d len %0d err %0d last %0b"},
                        e.tok.ttype, e.tok.offset, e.tok.length, e.tok.err, e.last,
                        o_token_type, o_token_offset, o_token_length, o_error_code,
                        o_last_result));
                end
            end
        end
    end

    // Token receiver: stall for a random spell before each transfer.
    initial begin
        int stall;
        i_out_ready = 1'b0;
        while (i_rst_n !== 1'b1)
            @(negedge i_clk);
        forever begin
            stall = out_idle_en ? $urandom_range(0, 19) : 0;
            if (stall > 0) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_ready <= 1'b1;
            do
                @(posedge i_clk);
            while (!(o_out_valid === 1'b1 && i_out_ready === 1'b1));
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = in_idle_en ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_text_byte  <= b;
        i_final_byte <= fin;
        do
            @(posedge i_clk);
        while (o_in_ready !== 1'b1);
        counted_bytes++;
        tokenize_byte(b, fin);
    endtask

    task automatic send_text(input t_text txt);
        foreach (txt[i])
            send_byte(txt[i], i == txt.size() - 1);
    endtask

    task automatic send_str(input string s);
        t_text t;
        for (int i = 0; i < s.len(); i++)
            t.insert(t.size(), s[i]);
        send_text(t);
    endtask

    // Mostly well-formed token runs with random content, some noise and cut-off endings.
    function automatic t_text build_random_text();
        t_text       t;
        string       punct = "{}[]:,";
        string       num_chars = "0123456789.eE+-";
        string       kw;
        logic [7:0]  c;
        int          cut;
        repeat ($urandom_range(1, 10)) begin
            case ($urandom_range(0, 15))
                0, 1, 2, 14: t.insert(t.size(), punct[$urandom_range(0, 5)]);
                3, 15: begin
                    cut = $urandom_range(0, 6);
                    c = (cut == 6) ? 8'd32 : 8'(9 + cut);
                    t.insert(t.size(), c);
                end
                4, 5, 6: begin
                    t.insert(t.size(), 8'h22);
                    repeat ($urandom_range(0, 6)) begin
                        cut = $urandom_range(0, 9);
                        if (cut == 0) begin
                            t.insert(t.size(), 8'h5C);
                            c = $urandom_range(0, 1) ? 8'h22 : 8'($urandom_range(32, 126));
                            t.insert(t.size(), c);
                        end else if (cut == 9) begin
                            c = 8'($urandom_range(128, 255));
                            t.insert(t.size(), c);
                        end else begin
                            c = 8'($urandom_range(32, 126));
                            t.insert(t.size(), (c == "\"") ? 8'h78 : c);
                        end
                    end
                    t.insert(t.size(), 8'h22);
                end
                7, 8, 9: begin
                    c = ($urandom_range(0, 4) == 0) ? 8'h2D : 8'(8'h30 + $urandom_range(0, 9));
                    t.insert(t.size(), c);
                    repeat ($urandom_range(0, 5))
                        t.insert(t.size(), num_chars[$urandom_range(0, 14)]);
                end
                10, 11: begin
                    kw = keyword_spelling[$urandom_range(0, 2)];
                    for (int i = 0; i < kw.len(); i++)
                        t.insert(t.size(), kw[i]);
                end
                12: begin
                    kw = keyword_spelling[$urandom_range(0, 2)];
                    cut = $urandom_range(1, kw.len() - 1);
                    for (int i = 0; i < cut; i++)
                        t.insert(t.size(), kw[i]);
                    c = 8'($urandom_range(0, 255));
                    t.insert(t.size(), c);
                end
                default: begin
                    c = 8'($urandom_range(0, 255));
                    t.insert(t.size(), c);
                end
            endcase
        end
        // cut some texts short so that they end inside a token
        if ($urandom_range(0, 5) == 0 && t.size() > 1) begin
            cut = $urandom_range(1, t.size() - 1);
            repeat (cut) void'(t.pop_back());
        end
        return t;
    endfunction

    task automatic test_punctuation();
        t_text t;
        send_str("{\t[:,]}");
        // the top byte of the range is an error; the rest of the text, the zero byte, is dropped
        t = '{8'hFF, 8'h00};
        send_text(t);
    endtask

    task automatic test_strings();
        // escaped backslash does not protect: the quote after it is still escaped
        send_str("\"\\\\\"a\"\"\"");
        send_str("\"");
    endtask

    task automatic test_numbers();
        send_str("-2e+.E,7");
    endtask

    task automatic test_keywords();
        send_str("nullfalse");
        send_str("true ");
        send_str("tr");
        send_str("tx");
    endtask

    task automatic test_random_texts();
        t_text t;
        counted_bytes = 0;
        while (counted_bytes < RANDOM_BYTES) begin
            in_idle_en  = ($urandom_range(0, 3) != 0);
            out_idle_en = ($urandom_range(0, 3) != 0);
            t = build_random_text();
            send_text(t);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_text_byte  = '0;
        i_final_byte = 1'b0;
        reset_scanner();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_punctuation();
        test_strings();
        test_numbers();
        test_keywords();
        test_random_texts();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
